@@ design/bhc_pkg.sv @@
// Shared types, codes and reset values for the button hold classifier.
package bhc_pkg;

  localparam int unsigned REG_W        = 8;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned COUNT_BITS_D = 8;

  localparam logic [REG_W-1:0] PAIR_HOLD_RST  = 8'd3;
  localparam logic [REG_W-1:0] RESET_HOLD_RST = 8'd20;
  localparam logic [REG_W-1:0] REBOOT_MIN_RST = 8'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAIR_HOLD  = 2'd0,
    CFG_RESET_HOLD = 2'd1,
    CFG_REBOOT_MIN = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_PAIR   = 2'd1,
    EV_RESET  = 2'd2,
    EV_REBOOT = 2'd3
  } event_t;

  typedef struct packed {
    logic [REG_W-1:0] pair_hold;
    logic [REG_W-1:0] reset_hold;
    logic [REG_W-1:0] reboot_min;
  } cfg_t;

  typedef struct packed {
    logic go;
    logic rd;
    logic pair_pressed;
    logic reset_pressed;
  } step_t;

endpackage

@@ design/bhc_core.sv @@
// Held counters, sticky events and the one-step update for one item.
module bhc_core #(
  parameter int unsigned COUNT_BITS = bhc_pkg::COUNT_BITS_D
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bhc_pkg::step_t   step,
  input  bhc_pkg::cfg_t    cfg,
  output bhc_pkg::event_t  ev
);

  // compare width covers both counter and threshold
  localparam int unsigned CMP_W = (COUNT_BITS > bhc_pkg::REG_W) ? COUNT_BITS : bhc_pkg::REG_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] pair_held_r,  pair_held_nxt;
  logic [COUNT_BITS-1:0] reset_held_r, reset_held_nxt;
  logic                  pair_pend_r,   pair_pend_nxt;
  logic                  reset_pend_r,  reset_pend_nxt;
  logic                  reboot_pend_r, reboot_pend_nxt;

  logic [COUNT_BITS-1:0] pair_inc, reset_inc;
  logic [CMP_W-1:0]      pair_inc_w, reset_inc_w, reset_held_w;
  logic [CMP_W-1:0]      pair_thr_w, reset_thr_w, reboot_thr_w;

  always_comb begin
    pair_inc  = (pair_held_r  == CNT_MAX) ? CNT_MAX : pair_held_r  + 1'b1;
    reset_inc = (reset_held_r == CNT_MAX) ? CNT_MAX : reset_held_r + 1'b1;

    pair_inc_w   = CMP_W'(pair_inc);
    reset_inc_w  = CMP_W'(reset_inc);
    reset_held_w = CMP_W'(reset_held_r);
    pair_thr_w   = CMP_W'(cfg.pair_hold);
    reset_thr_w  = CMP_W'(cfg.reset_hold);
    reboot_thr_w = CMP_W'(cfg.reboot_min);

    pair_held_nxt   = pair_held_r;
    reset_held_nxt  = reset_held_r;
    pair_pend_nxt   = pair_pend_r;
    reset_pend_nxt  = reset_pend_r;
    reboot_pend_nxt = reboot_pend_r;
    ev              = bhc_pkg::EV_NONE;

    if (step.rd) begin
      // highest pending event wins and only that one clears
      priority if (pair_pend_r) begin
        ev = bhc_pkg::EV_PAIR;
      end else if (reset_pend_r) begin
        ev = bhc_pkg::EV_RESET;
      end else if (reboot_pend_r) begin
        ev = bhc_pkg::EV_REBOOT;
      end else begin
        ev = bhc_pkg::EV_NONE;
      end
    end

    if (step.go) begin
      if (step.rd) begin
        priority if (pair_pend_r) begin
          pair_pend_nxt = 1'b0;
        end else if (reset_pend_r) begin
          reset_pend_nxt = 1'b0;
        end else if (reboot_pend_r) begin
          reboot_pend_nxt = 1'b0;
        end else begin
          // nothing pending, nothing to clear
        end
      end else if (step.pair_pressed) begin
        // reset button ignored, its count frozen
        pair_held_nxt = pair_inc;
        if (pair_inc_w >= pair_thr_w) begin
          pair_pend_nxt = 1'b1;
        end
      end else begin
        pair_held_nxt = '0;
        if (step.reset_pressed) begin
          reset_held_nxt = reset_inc;
          if (reset_inc_w >= reset_thr_w) begin
            reset_pend_nxt = 1'b1;
          end
        end else begin
          if (reset_held_w >= reboot_thr_w && reset_held_w < reset_thr_w) begin
            reboot_pend_nxt = 1'b1;
          end
          reset_held_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_held_r   <= '0;
      reset_held_r  <= '0;
      pair_pend_r   <= 1'b0;
      reset_pend_r  <= 1'b0;
      reboot_pend_r <= 1'b0;
    end else begin
      pair_held_r   <= pair_held_nxt;
      reset_held_r  <= reset_held_nxt;
      pair_pend_r   <= pair_pend_nxt;
      reset_pend_r  <= reset_pend_nxt;
      reboot_pend_r <= reboot_pend_nxt;
    end
  end

endmodule

@@ design/button_hold_classifier.sv @@
// Top level of the button hold classifier: input stage, settings, result register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------
//  in_     | in        | in_valid / in_stall | in_opcode, in_pair_pin, in_reset_pin
//  out_    | out       | out_valid/out_stall | out_event_code
//  cfg_    | in        | cfg_we              | cfg_index, cfg_wdata
//
// One item per cycle sustained while in_stall is low. An accepted item sits
// in the input stage, where the counter and event logic acts on it; a read's
// event code is then registered in the result register and shows on out_.
// Ticks give no item on out_.
// in_stall rises only when the stage holds a read and the result register is
// still full and stalled; ticks behind it wait so order is kept.
// rst_n is synchronous: counters and events clear, settings return to 3/20/3.
module button_hold_classifier #(
  parameter int unsigned COUNT_BITS = bhc_pkg::COUNT_BITS_D
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // item input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_opcode,
  input  logic                                 in_pair_pin,
  input  logic                                 in_reset_pin,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_event_code,
  // settings write port
  input  logic                                 cfg_we,
  input  logic [bhc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bhc_pkg::REG_W-1:0]            cfg_wdata
);

  bhc_pkg::cfg_t    cfg_r;
  bhc_pkg::step_t   step;
  bhc_pkg::event_t  ev;

  // input stage
  logic stg_valid_r;
  logic stg_op_r;
  logic stg_pair_r;
  logic stg_reset_r;

  // result register
  logic       out_valid_r;
  logic [1:0] out_code_r;

  logic in_accept;
  logic blocked;

  // a read may only leave the stage when the result register can take it
  assign blocked   = stg_valid_r && (stg_op_r == bhc_pkg::OP_READ) && out_valid_r && out_stall;
  assign in_stall  = blocked;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    step.go            = stg_valid_r && !blocked;
    step.rd            = (stg_op_r == bhc_pkg::OP_READ);
    step.pair_pressed  = !stg_pair_r;   // pins are active low
    step.reset_pressed = !stg_reset_r;
  end

  bhc_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .cfg   (cfg_r),
    .ev    (ev)
  );

  // settings; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pair_hold  <= bhc_pkg::PAIR_HOLD_RST;
      cfg_r.reset_hold <= bhc_pkg::RESET_HOLD_RST;
      cfg_r.reboot_min <= bhc_pkg::REBOOT_MIN_RST;
    end else if (cfg_we) begin
      unique case (bhc_pkg::cfg_idx_t'(cfg_index))
        bhc_pkg::CFG_PAIR_HOLD:  cfg_r.pair_hold  <= cfg_wdata;
        bhc_pkg::CFG_RESET_HOLD: cfg_r.reset_hold <= cfg_wdata;
        bhc_pkg::CFG_REBOOT_MIN: cfg_r.reboot_min <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_accept) begin
      stg_valid_r <= 1'b1;
    end else if (step.go) begin
      stg_valid_r <= 1'b0;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      stg_op_r    <= in_opcode;
      stg_pair_r  <= in_pair_pin;
      stg_reset_r <= in_reset_pin;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step.go && step.rd) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.go && step.rd) begin
      out_code_r <= ev;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_code = out_code_r;

endmodule

@@ design/bhc_checker.sv @@
// Port-level checks for the button hold classifier, bound to the top level.
module bhc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_event_code
);

  // nothing comes out straight after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // input only backs up behind a full, stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_event_code)))
    else $error("stalled result changed");

endmodule

bind button_hold_classifier bhc_checker u_bhc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_event_code (out_event_code)
);

@@ test/testbench.sv @@
// Self-checking testbench for the button hold classifier: random button traffic against a predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CNT_W          = bhc_pkg::COUNT_BITS_D;
  localparam int unsigned THR_W          = bhc_pkg::REG_W;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned DRAIN_CYCLES   = 6;

  // One input item as the driver offers it
  typedef struct packed {
    bhc_pkg::opcode_t op;
    logic             pair_pin;
    logic             reset_pin;
  } btn_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_opcode = 1'b0;
  logic             in_pair_pin = 1'b1;
  logic             in_reset_pin = 1'b1;
  logic             in_stall;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_event_code;
  logic             cfg_we = 1'b0;
  logic [bhc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [THR_W-1:0] cfg_wdata = '0;

  button_hold_classifier DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_pair_pin    (in_pair_pin),
    .in_reset_pin   (in_reset_pin),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_code (out_event_code),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Items waiting to be offered, and event codes the block still owes us
  btn_item_t        button_items[$];
  bhc_pkg::event_t  owed_events[$];

  // Predictor copy of the thresholds (reset values 3 / 20 / 3)
  logic [THR_W-1:0] pair_thr    = bhc_pkg::PAIR_HOLD_RST;
  logic [THR_W-1:0] factory_thr = bhc_pkg::RESET_HOLD_RST;
  logic [THR_W-1:0] reboot_thr  = bhc_pkg::REBOOT_MIN_RST;

  // Predictor copy of counters and sticky events
  logic [CNT_W-1:0] pair_count = '0;
  logic [CNT_W-1:0] factory_count = '0;
  logic             pair_flag = 1'b0;
  logic             factory_flag = 1'b0;
  logic             reboot_flag = 1'b0;

  int unsigned faults = 0;
  int unsigned shown = 0;
  bit          calm = 1'b0;   // no idling on either side once set

  // Work out what one accepted item does to the predicted state.
  // Ticks only move counters and flags; a read owes one event code.
  task automatic classify_item(btn_item_t it);
    if (it.op == bhc_pkg::OP_TICK) begin
      if (!it.pair_pin) begin
        // pair button pressed: the reset button is not looked at
        if (pair_count != '1) pair_count++;
        if (pair_count >= pair_thr) pair_flag = 1'b1;
      end else begin
        pair_count = '0;
        if (!it.reset_pin) begin
          if (factory_count != '1) factory_count++;
          if (factory_count >= factory_thr) factory_flag = 1'b1;
        end else begin
          // released: a hold of at least the reboot minimum but short of the reset threshold is a reboot request
          if (factory_count >= reboot_thr && factory_count < factory_thr) reboot_flag = 1'b1;
          factory_count = '0;
        end
      end
    end else begin
      // highest priority first, only that one cleared
      if (pair_flag) begin
        pair_flag = 1'b0;
        owed_events.push_back(bhc_pkg::EV_PAIR);
      end else if (factory_flag) begin
        factory_flag = 1'b0;
        owed_events.push_back(bhc_pkg::EV_RESET);
      end else if (reboot_flag) begin
        reboot_flag = 1'b0;
        owed_events.push_back(bhc_pkg::EV_REBOOT);
      end else begin
        owed_events.push_back(bhc_pkg::EV_NONE);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: offers queued items, with random gaps between them.
  // Payload holds still while in_stall is high.
  // ---------------------------------------------------------------------
  int unsigned send_gap = 0;
  logic        offering;
  btn_item_t   next_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offering = in_valid;
      if (in_valid && !in_stall) begin
        classify_item('{op: bhc_pkg::opcode_t'(in_opcode), pair_pin: in_pair_pin,
                        reset_pin: in_reset_pin});
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (button_items.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 17) - 1;
          in_valid <= 1'b0;
        end else if (button_items.size() != 0) begin
          next_item = button_items.pop_front();
          in_valid     <= 1'b1;
          in_opcode    <= next_item.op;
          in_pair_pin  <= next_item.pair_pin;
          in_reset_pin <= next_item.reset_pin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each event code against the oldest owed one.
  // Stalls in random bursts, plus one long hold-off once 10 items
  // have come out, so the block backs up and stalls its input.
  // ---------------------------------------------------------------------
  int unsigned     recv_gap = 0;
  int unsigned     long_left = 0;
  int unsigned     events_seen = 0;
  bit              long_done = 1'b0;
  bhc_pkg::event_t owed;

  task automatic note_fault(string what, int exp_code, int got_code);
    faults++;
    if (shown < 10) begin
      shown++;
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, exp_code, got_code);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        events_seen++;
        if (owed_events.size() == 0) begin
          note_fault("event code with none owed", -1, out_event_code);
        end else begin
          owed = owed_events.pop_front();
          if (out_event_code !== owed) note_fault("event code mismatch", owed, out_event_code);
        end
        if (events_seen == 10 && !long_done) begin
          long_done = 1'b1;
          long_left = LONG_HOLD;
        end
      end
      if (long_left > 0) begin
        long_left--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(1, 17) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too long with nothing accepted on either channel
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[button_hold_classifier] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers. Items are queued at the falling edge only.
  // ---------------------------------------------------------------------
  task automatic add_tick(logic pp, logic rp);
    button_items.push_back('{op: bhc_pkg::OP_TICK, pair_pin: pp, reset_pin: rp});
  endtask

  task automatic add_read();
    // pins mean nothing on a read, so they are random
    button_items.push_back('{op: bhc_pkg::OP_READ, pair_pin: 1'($urandom),
                             reset_pin: 1'($urandom)});
  endtask

  // pair button held n ticks (reset pin is don't-care meanwhile), then let go
  task automatic add_pair_hold(int unsigned n);
    repeat (n) add_tick(1'b0, 1'($urandom));
    add_tick(1'b1, 1'b1);
  endtask

  // reset button alone held n ticks, then let go
  task automatic add_factory_hold(int unsigned n);
    repeat (n) add_tick(1'b1, 1'b0);
    add_tick(1'b1, 1'b1);
  endtask

  // hold length around a threshold, kept short
  function automatic int unsigned hold_len(logic [THR_W-1:0] thr);
    int unsigned lim;
    lim = int'(thr) + 3;
    if (lim > 40) lim = 40;
    return $urandom_range(0, lim);
  endfunction

  // Mostly button presses of sensible length with reads between them;
  // some plain noise ticks on top.
  task automatic add_random(int unsigned n);
    int unsigned start;
    int unsigned pick;
    start = button_items.size();
    while (button_items.size() - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) add_read();
      else if (pick < 60) add_factory_hold(hold_len(factory_thr));
      else if (pick < 75) add_pair_hold(hold_len(pair_thr));
      else add_tick(1'($urandom), 1'($urandom));
    end
  endtask

  // Wait until the block has taken everything and owes nothing, then
  // give a tick that is still in the stage time to settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (button_items.size() != 0 || in_valid || owed_events.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(bhc_pkg::cfg_idx_t idx, logic [THR_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bhc_pkg::CFG_PAIR_HOLD:  pair_thr = val;
      bhc_pkg::CFG_RESET_HOLD: factory_thr = val;
      bhc_pkg::CFG_REBOOT_MIN: reboot_thr = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_thresholds(logic [THR_W-1:0] p, logic [THR_W-1:0] r,
                                logic [THR_W-1:0] b);
    wait_idle();
    write_reg(bhc_pkg::CFG_PAIR_HOLD, p);
    write_reg(bhc_pkg::CFG_RESET_HOLD, r);
    write_reg(bhc_pkg::CFG_REBOOT_MIN, b);
  endtask

  function automatic logic [THR_W-1:0] rand_thr();
    if ($urandom_range(0, 4) == 0) return THR_W'($urandom_range(0, 255));
    return THR_W'($urandom_range(1, 10));
  endfunction

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values 3 / 20 / 3: empty read, pair, reboot, too-short hold
    add_read();
    add_pair_hold(3);
    add_read();
    add_read();
    add_factory_hold(4);
    add_read();
    add_factory_hold(2);
    add_read();
    add_random(40);

    // All thresholds zero: both buttons fire on their first pressed tick,
    // then reads drain in priority order
    set_thresholds(8'd0, 8'd0, 8'd0);
    add_tick(1'b0, 1'b0);
    add_tick(1'b1, 1'b0);
    add_tick(1'b1, 1'b1);
    add_read();
    add_read();
    add_read();
    add_random(20);

    // Zero reboot minimum: a release with no hold before it is a reboot.
    // Unused register index is written too and must change nothing.
    set_thresholds(8'd4, 8'd5, 8'd0);
    write_reg(bhc_pkg::CFG_UNUSED, THR_W'($urandom));
    add_tick(1'b1, 1'b1);
    add_read();
    add_pair_hold(4);
    add_factory_hold(5);
    add_tick(1'b1, 1'b1);
    add_read();
    add_read();
    add_read();
    add_read();
    add_random(30);

    // Top thresholds: the reset counter saturates and still meets 255;
    // a counter that wrapped would look like a short hold on release
    set_thresholds(8'd255, 8'd255, 8'd1);
    add_factory_hold(258);
    add_read();
    add_read();

    set_thresholds(8'd1, 8'd1, 8'd1);
    add_random(40);

    // Reboot minimum at the top: reboot can never latch
    set_thresholds(8'd2, 8'd255, 8'd255);
    add_random(30);

    repeat (2) begin
      set_thresholds(rand_thr(), rand_thr(), rand_thr());
      add_random(30);
    end

    // Last stretch runs flat out on both sides
    set_thresholds(8'd3, 8'd6, 8'd2);
    calm = 1'b1;
    add_random(50);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (faults == 0 && owed_events.size() == 0) begin
      $display("[button_hold_classifier] OK");
    end else begin
      $display("[button_hold_classifier] ERROR");
    end
    $finish;
  end

endmodule
